// ===== rtl/core/bmam_pkg.sv =====
package bmam_pkg;

	localparam int IDX_W  = 10;  // row / column index
	localparam int REG_W  = 11;  // order and block edge registers
	localparam int ADDR_W = 20;  // element offset
	localparam int MUL_W  = IDX_W + REG_W;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [REG_W-1:0] ORDER_RST = REG_W'(1024);
	localparam logic [REG_W-1:0] EDGE_RST  = REG_W'(64);

	typedef enum logic {
		REG_ORDER = 1'b0,
		REG_EDGE  = 1'b1
	} reg_idx_t;

	// remainder pipeline payload
	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [REG_W-1:0] row_rem;
		logic [REG_W-1:0] col_rem;
		logic             err;
	} div_t;

	// block geometry
	typedef struct packed {
		logic [IDX_W-1:0] base_r;
		logic [IDX_W-1:0] base_c;
		logic [IDX_W-1:0] prow;
		logic [IDX_W-1:0] pcol;
		logic [REG_W-1:0] height;
		logic [REG_W-1:0] width;
		logic             err;
	} geo_t;

	typedef struct packed {
		logic [ADDR_W-1:0] p_row;
		logic [ADDR_W-1:0] p_col;
		logic [ADDR_W-1:0] p_in;
		logic [IDX_W-1:0]  pcol;
		logic              err;
	} mul_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              err;
	} res_t;

	// one restoring division step: shift in the next dividend bit
	function automatic logic [REG_W-1:0] rem_step(
		input logic [REG_W-1:0] rem,
		input logic             bit_in,
		input logic [REG_W-1:0] div
	);
		logic [REG_W:0] t;
		logic [REG_W:0] d;
		t = {rem, bit_in};
		d = {1'b0, div};
		if (t >= d) begin
			rem_step = REG_W'(t - d);
		end else begin
			rem_step = t[REG_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/block_matrix_address_map_core.sv =====
// 14 register stages from the accepting edge to result valid: one input stage,
// one stage per index bit for the two remainder dividers, then geometry,
// multiply and sum stages.
// Throughput: one request per cycle; an empty stage takes new data even while the
// result is stalled, so requests keep entering until every stage is full.
// Reset (arst_n low, asynchronous): pipeline empty, matrix_order = 1024, block_edge = 64.
module block_matrix_address_map_core #(
	parameter int MAX_ORDER = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// APB configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [bmam_pkg::APB_AW-1:0]          paddr,
	input  logic [bmam_pkg::APB_DW-1:0]          pwdata,
	output logic [bmam_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready,
	// request stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [bmam_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // row_index[9:0], col_index[19:10]
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [bmam_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // word_address[19:0]
	output logic                                 m_axis_tuser   // index_error[0]
);
	import bmam_pkg::*;

	localparam int ST_GEO = IDX_W + 1;
	localparam int ST_MUL = IDX_W + 2;
	localparam int ST_OUT = IDX_W + 3;
	localparam int STAGES = IDX_W + 4;

	logic [REG_W-1:0]  matrix_order_q;
	logic [REG_W-1:0]  block_edge_q;

	logic [STAGES-1:0] vld_s;
	logic [STAGES-1:0] adv;

	div_t dv_s [IDX_W+1];
	geo_t geo_s12;
	mul_t mul_s13;
	res_t res_s14;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_order_q <= ORDER_RST;
			block_edge_q   <= EDGE_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_ORDER: matrix_order_q <= pwdata[REG_W-1:0];
				REG_EDGE:  block_edge_q   <= pwdata[REG_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_ORDER: prdata = APB_DW'(matrix_order_q);
			REG_EDGE:  prdata = APB_DW'(block_edge_q);
			default:   prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// a stage takes new data when it is empty or its contents move on
	always_comb begin
		adv[STAGES-1] = !vld_s[STAGES-1] || m_axis_tready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign s_axis_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// ---------------- input stage ----------------
	logic [IDX_W-1:0] in_row;
	logic [IDX_W-1:0] in_col;
	logic             in_err;

	assign in_row = s_axis_tdata[IDX_W-1:0];
	assign in_col = s_axis_tdata[2*IDX_W-1:IDX_W];

	always_comb begin
		in_err = (matrix_order_q == '0)
			|| (32'(matrix_order_q) > 32'(MAX_ORDER))
			|| (block_edge_q == '0)
			|| (block_edge_q > matrix_order_q)
			|| ({1'b0, in_row} >= matrix_order_q)
			|| ({1'b0, in_col} >= matrix_order_q);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dv_s[0].row     <= in_row;
			dv_s[0].col     <= in_col;
			dv_s[0].row_rem <= '0;
			dv_s[0].col_rem <= '0;
			dv_s[0].err     <= in_err;
		end
	end

	// ---------------- remainder stages ----------------
	// stage d brings in index bit IDX_W-d, MSB first
	for (genvar d = 1; d <= IDX_W; d++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[d]) begin
				dv_s[d].row     <= dv_s[d-1].row;
				dv_s[d].col     <= dv_s[d-1].col;
				dv_s[d].err     <= dv_s[d-1].err;
				dv_s[d].row_rem <= rem_step(dv_s[d-1].row_rem,
					dv_s[d-1].row[IDX_W-d], block_edge_q);
				dv_s[d].col_rem <= rem_step(dv_s[d-1].col_rem,
					dv_s[d-1].col[IDX_W-d], block_edge_q);
			end
		end
	end

	// ---------------- block geometry ----------------
	// base = start of the element's block; short edge blocks are those that
	// would run past the matrix order
	div_t             dv_last;
	logic [IDX_W-1:0] g_base_r;
	logic [IDX_W-1:0] g_base_c;
	logic [REG_W:0]   g_end_r;
	logic [REG_W:0]   g_end_c;

	assign dv_last  = dv_s[IDX_W];
	assign g_base_r = dv_last.row - dv_last.row_rem[IDX_W-1:0];
	assign g_base_c = dv_last.col - dv_last.col_rem[IDX_W-1:0];
	assign g_end_r  = (REG_W+1)'(g_base_r) + (REG_W+1)'(block_edge_q);
	assign g_end_c  = (REG_W+1)'(g_base_c) + (REG_W+1)'(block_edge_q);

	always_ff @(posedge clk) begin
		if (adv[ST_GEO]) begin
			geo_s12.base_r <= g_base_r;
			geo_s12.base_c <= g_base_c;
			geo_s12.prow   <= dv_last.row_rem[IDX_W-1:0];
			geo_s12.pcol   <= dv_last.col_rem[IDX_W-1:0];
			geo_s12.height <= (g_end_r > (REG_W+1)'(matrix_order_q))
				? matrix_order_q - REG_W'(g_base_r) : block_edge_q;
			geo_s12.width  <= (g_end_c > (REG_W+1)'(matrix_order_q))
				? matrix_order_q - REG_W'(g_base_c) : block_edge_q;
			geo_s12.err    <= dv_last.err;
		end
	end

	// ---------------- products ----------------
	logic [MUL_W-1:0] m_row;
	logic [MUL_W-1:0] m_col;
	logic [MUL_W-1:0] m_in;

	assign m_row = MUL_W'(geo_s12.base_r) * MUL_W'(matrix_order_q);
	assign m_col = MUL_W'(geo_s12.base_c) * MUL_W'(geo_s12.height);
	assign m_in  = MUL_W'(geo_s12.prow) * MUL_W'(geo_s12.width);

	always_ff @(posedge clk) begin
		if (adv[ST_MUL]) begin
			mul_s13.p_row <= m_row[ADDR_W-1:0];
			mul_s13.p_col <= m_col[ADDR_W-1:0];
			mul_s13.p_in  <= m_in[ADDR_W-1:0];
			mul_s13.pcol  <= geo_s12.pcol;
			mul_s13.err   <= geo_s12.err;
		end
	end

	// ---------------- sum / output register ----------------
	logic [ADDR_W-1:0] sum;

	assign sum = mul_s13.p_row + mul_s13.p_col + mul_s13.p_in + ADDR_W'(mul_s13.pcol);

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			res_s14.addr <= mul_s13.err ? '0 : sum;
			res_s14.err  <= mul_s13.err;
		end
	end

	assign m_axis_tvalid = vld_s[ST_OUT];
	assign m_axis_tdata  = OUT_TDATA_W'(res_s14.addr);
	assign m_axis_tuser  = res_s14.err;

	// ---------------- assertions ----------------
	a_row_range_err: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && ({1'b0, in_row} >= matrix_order_q)
		|=> vld_s[0] && dv_s[0].err)
		else $error("out-of-range row not flagged at input stage");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[IDX_W] && !dv_last.err
		|-> (dv_last.row_rem < block_edge_q) && (dv_last.col_rem < block_edge_q))
		else $error("remainder not below block edge");

	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result carries nonzero address");

endmodule

// ===== sim/tb_block_matrix_address_map_core.sv =====
`timescale 1ns / 100ps

module tb_block_matrix_address_map_core;
	import bmam_pkg::*;

	localparam int MAX_ORDER = 1024;

	typedef struct {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [ADDR_W-1:0] addr;
		logic              err;
	} elem_addr_t;

	class address_checker;
		logic [REG_W-1:0] order    = ORDER_RST;
		logic [REG_W-1:0] blk_edge = EDGE_RST;
		elem_addr_t       queued_addrs[$];
		int               fails;

		function void set_reg(reg_idx_t idx, logic [REG_W-1:0] v);
			if (idx == REG_ORDER) begin
				order = v;
			end else begin
				blk_edge = v;
			end
		endfunction

		function elem_addr_t block_major_offset(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
			longint unsigned n, m, i, j, s, r, brow, bcol, height, width, a;
			elem_addr_t e;
			n = order;
			m = blk_edge;
			i = row;
			j = col;
			e.row = row;
			e.col = col;
			if (n == 0 || n > MAX_ORDER || m == 0 || m > n || i >= n || j >= n) begin
				e.addr = '0;
				e.err  = 1'b1;
				return e;
			end
			s    = n / m;
			r    = n % m;
			brow = i / m;
			bcol = j / m;
			// short blocks only on the last block row / column
			height = (r != 0 && brow == s) ? r : m;
			width  = (r != 0 && bcol == s) ? r : m;
			a = brow * m * n + bcol * m * height + (i % m) * width + (j % m);
			e.addr = a[ADDR_W-1:0];
			e.err  = 1'b0;
			return e;
		endfunction

		function void note_request(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
			queued_addrs.push_back(block_major_offset(row, col));
		endfunction

		function void check_result(logic [ADDR_W-1:0] addr, logic err);
			elem_addr_t e;
			if (queued_addrs.size() == 0) begin
				$display("%0t: unexpected result addr %0h err %0b", $time, addr, err);
				fails++;
				return;
			end
			e = queued_addrs.pop_front();
			if (addr !== e.addr) begin
				$display("%0t: row %0d col %0d word_address expected %0h actual %0h",
					$time, e.row, e.col, e.addr, addr);
				fails++;
			end
			if (err !== e.err) begin
				$display("%0t: row %0d col %0d index_error expected %0b actual %0b",
					$time, e.row, e.col, e.err, err);
				fails++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // row_index[9:0], col_index[19:10]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // word_address[19:0]
	logic                   m_axis_tuser;        // index_error[0]

	address_checker sb;
	bit             idle_on = 1'b1;
	bit             stall_on = 1'b1;

	block_matrix_address_map_core #(.MAX_ORDER(MAX_ORDER)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_block_matrix_address_map_core NOT OK");
		$finish;
	end

	task automatic apb_write(input reg_idx_t idx, input logic [REG_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic check_reg(input reg_idx_t idx, input logic [REG_W-1:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== APB_DW'(v)) begin
			$display("%0t: register %s read expected %0h actual %0h", $time, idx.name(), v, prdata);
			sb.fails++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// valid stays high across back-to-back requests; it drops only for a gap or in drain()
	task automatic send_request(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, col, row};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.note_request(row, col);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.queued_addrs.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_geometry(input int n, input int m);
		drain();
		apb_write(REG_ORDER, REG_W'(n));
		apb_write(REG_EDGE, REG_W'(m));
		check_reg(REG_ORDER, REG_W'(n));
		check_reg(REG_EDGE, REG_W'(m));
	endtask

	// mostly in range, with the last row/col and some out-of-range picks
	function automatic logic [IDX_W-1:0] pick_index(input int n);
		int s;
		s = $urandom_range(0, 9);
		if (n < 1 || n > MAX_ORDER || s == 0) begin
			return IDX_W'($urandom_range(0, 1023));
		end
		if (s == 1) begin
			return IDX_W'(n - 1);
		end
		return IDX_W'($urandom_range(0, n - 1));
	endfunction

	// result side
	initial begin
		int stall;
		forever begin
			stall = stall_on ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1 || arst_n !== 1'b1);
			sb.check_result(m_axis_tdata[ADDR_W-1:0], m_axis_tuser);
		end
	end

	initial begin
		int n;
		int m;
		int sel;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(REG_ORDER, ORDER_RST);
		check_reg(REG_EDGE, EDGE_RST);

		// reset geometry: corners and alternating bits
		send_request(10'd0, 10'd0);
		send_request(10'd1023, 10'd1023);
		send_request(10'd1023, 10'd0);
		send_request(10'd0, 10'd1023);
		send_request(10'd63, 10'd64);
		send_request(10'h2AA, 10'h155);
		send_request(10'h155, 10'h2AA);
		// order not a multiple of the edge: short right, bottom and corner blocks
		set_geometry(1000, 64);
		send_request(10'd999, 10'd999);
		send_request(10'd999, 10'd5);
		send_request(10'd5, 10'd999);
		send_request(10'd960, 10'd959);
		set_geometry(1, 1);
		send_request(10'd0, 10'd0);
		send_request(10'd1, 10'd0);
		// zero order
		set_geometry(0, 5);
		send_request(10'd0, 10'd0);
		// order above the maximum
		set_geometry(1025, 64);
		send_request(10'd0, 10'd0);
		// zero edge
		set_geometry(100, 0);
		send_request(10'd0, 10'd0);
		// edge above order
		set_geometry(50, 60);
		send_request(10'd3, 10'd3);
		set_geometry(1024, 1024);
		send_request(10'd1023, 10'd1023);
		send_request(10'd512, 10'd3);
		set_geometry(1024, 1);
		send_request(10'd1023, 10'd1023);
		send_request(10'd0, 10'd1023);

		for (int p = 0; p < 20; p++) begin
			sel = $urandom_range(0, 19);
			case (sel)
				0: n = 0;
				1: n = $urandom_range(1025, 2047);
				2: n = 1;
				3: n = 1024;
				4, 5, 6: n = $urandom_range(1, 16);
				default: n = $urandom_range(2, 1024);
			endcase
			sel = $urandom_range(0, 9);
			if (n == 0) begin
				m = $urandom_range(0, 64);
			end else if (sel == 0) begin
				m = 0;
			end else if (sel == 1 && n < 2047) begin
				m = $urandom_range(n + 1, 2047);
			end else if (sel == 2) begin
				m = 1;
			end else if (sel == 3) begin
				m = n;
			end else begin
				m = $urandom_range(1, n);
			end
			set_geometry(n, m);
			idle_on  = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			repeat (45) send_request(pick_index(n), pick_index(n));
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.queued_addrs.size() == 0) begin
			$display("tb_block_matrix_address_map_core OK");
		end else begin
			$display("tb_block_matrix_address_map_core NOT OK");
		end
		$finish;
	end

endmodule
